FILE: rtl/chpd_pkg.sv
package chpd_pkg;

    localparam int BYTE_W     = 8;
    localparam int NODE_W     = 9;
    localparam int COLOR_W    = 24;
    localparam int WEIGHT_W   = 16;
    localparam int CHILD_AW   = 16;
    localparam int NODES      = 512;
    localparam int RESULT_CAP = 64;
    localparam int CNT_W      = 7;
    localparam int SKIP_BYTES = 4;
    localparam int WIDTH_W    = 10;
    localparam int HEIGHT_W   = 9;

    localparam logic [1:0] MODE_COUNT   = 2'd0;
    localparam logic [1:0] MODE_PALETTE = 2'd1;
    localparam logic [1:0] MODE_DATA    = 2'd2;
    localparam logic [1:0] MODE_RESUME  = 2'd3;

    localparam logic CFG_WIDTH  = 1'b0;
    localparam logic CFG_HEIGHT = 1'b1;

    localparam logic KIND_PIXEL = 1'b0;
    localparam logic KIND_ERROR = 1'b1;

    typedef struct packed {
        logic              en;
        logic              build;
        logic [BYTE_W-1:0] col;
        logic [BYTE_W-1:0] row;
        logic [BYTE_W-1:0] count;
    } t_count_wr;

    typedef struct packed {
        logic                  en;
        logic [CHILD_AW-1:0]   addr;
        logic [2*NODE_W-1:0]   data;
    } t_child_wr;

    typedef struct packed {
        logic              en;
        logic [BYTE_W-1:0] addr;
        logic [NODE_W-1:0] data;
    } t_root_wr;

endpackage

FILE: rtl/context_huffman_pixel_decoder.sv
// A pixel steps through loop check, root read (skipped when a parked walk resumes), leaf test
// and pixel step, with a walk step and a child read per code bit; each word is held back one word
// so the final word of an item can carry last. A frame byte yields up to 64 words.
// Items are taken one at a time: start is not accepted while busy is high.
// A count byte that closes a row starts a tree build: per joined node one scan of the weight
// memory, for nodes from SYMBOLS up. Synchronous active-low reset clears control state.
module context_huffman_pixel_decoder
    import chpd_pkg::*;
#(
    parameter int SYMBOLS    = 256,
    parameter int MAX_WIDTH  = 640,
    parameter int MAX_HEIGHT = 480
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_mode,
    input  logic [BYTE_W-1:0]   i_data_byte,
    input  logic [COLOR_W-1:0]  i_entry_color,
    input  logic                i_first_of_frame,
    input  logic                i_last_of_frame,
    input  logic                i_cfg_we,
    input  logic                i_cfg_index,
    input  logic [WIDTH_W-1:0]  i_cfg_data,
    output logic                o_valid,
    output logic                o_kind,
    output logic [BYTE_W-1:0]   o_pixel_index,
    output logic [COLOR_W-1:0]  o_pixel_color,
    output logic                o_frame_end,
    output logic                o_last
);

    localparam int SB   = $clog2(SYMBOLS);
    localparam int CW_W = $clog2(MAX_WIDTH + 1);
    localparam int CH_W = $clog2(MAX_HEIGHT + 1);
    localparam int PD_W = $clog2(MAX_WIDTH * MAX_HEIGHT + 1);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_LOOP  = 7'b0000010,
        S_ROOT  = 7'b0000100,
        S_WALK  = 7'b0001000,
        S_CHILD = 7'b0010000,
        S_PIX   = 7'b0100000,
        S_FIN   = 7'b1000000
    } t_state;

    // stores: per-context trees, roots and palette
    logic [2*NODE_W-1:0] r_child_mem [1 << CHILD_AW];
    logic [NODE_W-1:0]   r_root_mem  [1 << BYTE_W];
    logic [COLOR_W-1:0]  r_pal_mem   [1 << BYTE_W];
    logic [2*NODE_W-1:0] r_child_q;
    logic [NODE_W-1:0]   r_root_q;
    logic [COLOR_W-1:0]  r_pal_q;

    t_state r_state, n_state;
    logic [BYTE_W-1:0]   r_prev, n_prev, r_buf, n_buf;
    logic [3:0]          r_bits, n_bits;
    logic [PD_W-1:0]     r_pd, n_pd, r_total;
    logic [2:0]          r_skip, n_skip;
    logic [NODE_W-1:0]   r_wnode, n_wnode, r_node, n_node;
    logic r_wvalid, n_wvalid, r_active, n_active, r_closed, n_closed, r_bit, n_bit;
    logic [CNT_W-1:0]    r_cnt, n_cnt;
    logic [SB-1:0]       r_col, n_col, r_row, n_row, r_pal, n_pal;
    logic [WIDTH_W-1:0]  r_width;
    logic [HEIGHT_W-1:0] r_height;

    logic                r_hold_v, r_hold_kind, r_hold_fend;
    logic [BYTE_W-1:0]   r_hold_idx;
    logic [COLOR_W-1:0]  r_hold_col;

    logic                p_en, p_kind, p_fend, fin, accept, bld_busy;
    logic [BYTE_W-1:0]   p_idx;
    logic [COLOR_W-1:0]  p_col;
    logic                pal_we;
    logic [NODE_W-1:0]   nsub;
    logic [PD_W-1:0]     pd_inc;
    logic [CW_W-1:0]     cw;
    logic [CH_W-1:0]     ch;
    t_count_wr           count_wr;
    t_child_wr           child_wr;
    t_root_wr            root_wr;

    chpd_tree_builder #(
        .SYMBOLS (SYMBOLS)
    ) u_builder (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_count (count_wr),
        .o_busy  (bld_busy),
        .o_child (child_wr),
        .o_root  (root_wr)
    );

    assign busy   = (r_state != S_IDLE) || bld_busy;
    assign accept = start && !busy;
    assign nsub   = r_node - NODE_W'(SYMBOLS);
    assign pd_inc = r_pd + PD_W'(1);

    // clamp the frame size, hold the pixel total in a register
    assign cw = (r_width == '0) ? CW_W'(1) :
                ((32'(r_width) > MAX_WIDTH) ? CW_W'(MAX_WIDTH) : CW_W'(r_width));
    assign ch = (r_height == '0) ? CH_W'(1) :
                ((32'(r_height) > MAX_HEIGHT) ? CH_W'(MAX_HEIGHT) : CH_W'(r_height));

    always_ff @(posedge i_clk) begin
        if (child_wr.en) begin
            r_child_mem[child_wr.addr] <= child_wr.data;
        end
        if (root_wr.en) begin
            r_root_mem[root_wr.addr] <= root_wr.data;
        end
        if (pal_we) begin
            r_pal_mem[BYTE_W'(r_pal)] <= i_entry_color;
        end
        r_child_q <= r_child_mem[{r_prev, nsub[BYTE_W-1:0]}];
        r_root_q  <= r_root_mem[r_prev];
        r_pal_q   <= r_pal_mem[r_node[BYTE_W-1:0]];
    end

    always_comb begin
        n_state  = r_state;
        n_prev   = r_prev;
        n_buf    = r_buf;
        n_bits   = r_bits;
        n_pd     = r_pd;
        n_skip   = r_skip;
        n_wnode  = r_wnode;
        n_wvalid = r_wvalid;
        n_active = r_active;
        n_closed = r_closed;
        n_node   = r_node;
        n_bit    = r_bit;
        n_cnt    = r_cnt;
        n_col    = r_col;
        n_row    = r_row;
        n_pal    = r_pal;
        pal_we   = 1'b0;
        count_wr = '0;
        p_en     = 1'b0;
        p_kind   = KIND_PIXEL;
        p_idx    = '0;
        p_col    = '0;
        p_fend   = 1'b0;
        fin      = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    unique case (i_mode)
                        MODE_COUNT: begin
                            count_wr.en    = 1'b1;
                            count_wr.col   = BYTE_W'(r_col);
                            count_wr.row   = BYTE_W'(r_row);
                            count_wr.count = i_data_byte;
                            if (r_col == SB'(SYMBOLS - 1)) begin
                                count_wr.build = 1'b1;
                                n_col = '0;
                                n_row = (r_row == SB'(SYMBOLS - 1)) ? '0 : r_row + SB'(1);
                            end else begin
                                n_col = r_col + SB'(1);
                            end
                        end
                        MODE_PALETTE: begin
                            pal_we = 1'b1;
                            n_pal  = (r_pal == SB'(SYMBOLS - 1)) ? '0 : r_pal + SB'(1);
                        end
                        MODE_DATA: begin
                            if (i_first_of_frame) begin
                                n_active = 1'b1;
                                n_closed = 1'b0;
                                n_skip   = 3'(SKIP_BYTES);
                                n_pd     = '0;
                                n_prev   = '0;
                                n_buf    = '0;
                                n_bits   = '0;
                                n_wvalid = 1'b0;
                            end
                            if (n_active && !n_closed) begin
                                if (n_skip != '0) begin
                                    n_skip = n_skip - 3'd1;
                                end else begin
                                    n_buf  = i_data_byte;
                                    n_bits = 4'd8;
                                end
                                if (i_last_of_frame) begin
                                    n_closed = 1'b1;
                                end
                                n_cnt   = '0;
                                n_state = S_LOOP;
                            end
                        end
                        MODE_RESUME: begin
                            n_cnt   = '0;
                            n_state = S_LOOP;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_LOOP: begin
                if (r_active && (r_pd < r_total) && (r_cnt < CNT_W'(RESULT_CAP))) begin
                    if (r_wvalid) begin
                        n_node  = r_wnode;
                        n_state = S_WALK;
                    end else begin
                        n_state = S_ROOT;
                    end
                end else begin
                    n_state = S_FIN;
                end
            end
            S_ROOT: begin
                n_node  = r_root_q;
                n_state = S_WALK;
            end
            S_WALK: begin
                if (r_node < NODE_W'(SYMBOLS)) begin
                    n_state = S_PIX;
                end else if (r_bits == '0) begin
                    // park the partial walk; a closed frame has run dry
                    n_wnode  = r_node;
                    n_wvalid = 1'b1;
                    if (r_closed) begin
                        p_en     = 1'b1;
                        p_kind   = KIND_ERROR;
                        n_active = 1'b0;
                    end
                    n_state = S_FIN;
                end else begin
                    n_bit   = r_buf[0];
                    n_buf   = r_buf >> 1;
                    n_bits  = r_bits - 4'd1;
                    n_state = S_CHILD;
                end
            end
            S_CHILD: begin
                n_node  = r_bit ? r_child_q[2*NODE_W-1:NODE_W] : r_child_q[NODE_W-1:0];
                n_state = S_WALK;
            end
            S_PIX: begin
                p_en     = 1'b1;
                p_idx    = r_node[BYTE_W-1:0];
                p_col    = r_pal_q;
                p_fend   = (pd_inc == r_total);
                n_wvalid = 1'b0;
                n_pd     = pd_inc;
                n_prev   = r_node[BYTE_W-1:0];
                n_cnt    = r_cnt + CNT_W'(1);
                if (pd_inc == r_total) begin
                    n_active = 1'b0;
                end
                n_state = S_LOOP;
            end
            S_FIN: begin
                fin     = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_prev   <= '0;
            r_buf    <= '0;
            r_bits   <= '0;
            r_pd     <= '0;
            r_skip   <= '0;
            r_wvalid <= 1'b0;
            r_active <= 1'b0;
            r_closed <= 1'b0;
            r_cnt    <= '0;
            r_col    <= '0;
            r_row    <= '0;
            r_pal    <= '0;
            r_width  <= WIDTH_W'(1);
            r_height <= HEIGHT_W'(1);
            r_hold_v <= 1'b0;
            o_valid  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_prev   <= n_prev;
            r_buf    <= n_buf;
            r_bits   <= n_bits;
            r_pd     <= n_pd;
            r_skip   <= n_skip;
            r_wvalid <= n_wvalid;
            r_active <= n_active;
            r_closed <= n_closed;
            r_cnt    <= n_cnt;
            r_col    <= n_col;
            r_row    <= n_row;
            r_pal    <= n_pal;
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_WIDTH) begin
                    r_width <= i_cfg_data;
                end else begin
                    r_height <= i_cfg_data[HEIGHT_W-1:0];
                end
            end
            // hold one word back so the final one can carry the last flag
            o_valid <= 1'b0;
            if (p_en) begin
                o_valid  <= r_hold_v;
                r_hold_v <= 1'b1;
            end else if (fin && r_hold_v) begin
                o_valid  <= 1'b1;
                r_hold_v <= 1'b0;
            end
        end
        r_wnode <= n_wnode;
        r_node  <= n_node;
        r_bit   <= n_bit;
        r_total <= PD_W'(cw) * PD_W'(ch);
        if (p_en) begin
            r_hold_kind <= p_kind;
            r_hold_idx  <= p_idx;
            r_hold_col  <= p_col;
            r_hold_fend <= p_fend;
        end
        if (p_en || fin) begin
            o_kind        <= r_hold_kind;
            o_pixel_index <= r_hold_idx;
            o_pixel_color <= r_hold_col;
            o_frame_end   <= r_hold_fend;
            o_last        <= !p_en;
        end
    end

    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_ERROR) |-> o_last)
        else $error("error word not last");
    a_err_noend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_kind == KIND_ERROR) |-> !o_frame_end)
        else $error("error word flags frame end");
    a_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CNT_W'(RESULT_CAP))
        else $error("result count past cap");
    a_fin_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FIN) |=> (r_state == S_IDLE) && !r_hold_v)
        else $error("held word not flushed");

endmodule

FILE: rtl/chpd_tree_builder.sv
module chpd_tree_builder
    import chpd_pkg::*;
#(
    parameter int SYMBOLS = 256
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_count_wr i_count,
    output logic      o_busy,
    output t_child_wr o_child,
    output t_root_wr  o_root
);

    typedef enum logic [5:0] {
        B_IDLE  = 6'b000001,
        B_START = 6'b000010,
        B_SCAN  = 6'b000100,
        B_DRAIN = 6'b001000,
        B_DEC   = 6'b010000,
        B_MARK2 = 6'b100000
    } t_bstate;

    // entry: taken flag over weight
    logic [WEIGHT_W:0] r_wmem [NODES];
    logic [WEIGHT_W:0] r_rdata;

    t_bstate r_state, n_state;
    logic [BYTE_W-1:0]   r_row, n_row;
    logic [NODE_W-1:0]   r_n, n_n, r_i, n_i, r_pidx, n_pidx;
    logic [NODE_W-1:0]   r_b1, n_b1, r_b2, n_b2;
    logic [WEIGHT_W-1:0] r_w1, n_w1, r_w2, n_w2;
    logic r_pend, n_pend, r_b1v, n_b1v, r_b2v, n_b2v, r_new, n_new;

    logic                we;
    logic [NODE_W-1:0]   waddr;
    logic [WEIGHT_W:0]   wdata;
    logic                cand;
    logic [WEIGHT_W-1:0] cw;
    logic [NODE_W-1:0]   nsub;

    always_ff @(posedge i_clk) begin
        if (we) begin
            r_wmem[waddr] <= wdata;
        end
        r_rdata <= r_wmem[r_i];
    end

    assign cand = r_pend && !r_rdata[WEIGHT_W] && (r_rdata[WEIGHT_W-1:0] != '0);
    assign cw   = r_rdata[WEIGHT_W-1:0];
    assign nsub = r_n - NODE_W'(SYMBOLS);

    always_comb begin
        n_state = r_state;
        n_row   = r_row;
        n_n     = r_n;
        n_i     = r_i;
        n_pidx  = r_pidx;
        n_pend  = 1'b0;
        n_b1    = r_b1;
        n_b2    = r_b2;
        n_w1    = r_w1;
        n_w2    = r_w2;
        n_b1v   = r_b1v;
        n_b2v   = r_b2v;
        n_new   = r_new;
        we      = 1'b0;
        waddr   = r_b1;
        wdata   = {1'b1, r_w1};
        o_child = '0;
        o_root  = '0;
        // track the two smallest live weights, lower index wins ties
        if (cand) begin
            if (!r_b1v || cw < r_w1) begin
                n_b2  = r_b1;
                n_w2  = r_w1;
                n_b2v = r_b1v;
                n_b1  = r_pidx;
                n_w1  = cw;
                n_b1v = 1'b1;
            end else if (!r_b2v || cw < r_w2) begin
                n_b2  = r_pidx;
                n_w2  = cw;
                n_b2v = 1'b1;
            end
        end
        unique case (r_state)
            B_IDLE: begin
                if (i_count.en) begin
                    we    = 1'b1;
                    waddr = {1'b0, i_count.col};
                    wdata = {1'b0, WEIGHT_W'(i_count.count)};
                    if (i_count.build) begin
                        n_row   = i_count.row;
                        n_n     = NODE_W'(SYMBOLS);
                        n_state = B_START;
                    end
                end
            end
            B_START: begin
                n_i     = '0;
                n_b1v   = 1'b0;
                n_b2v   = 1'b0;
                n_new   = 1'b0;
                n_state = B_SCAN;
            end
            B_SCAN: begin
                n_pend = 1'b1;
                n_pidx = r_i;
                if (r_i == r_n - NODE_W'(1)) begin
                    n_state = B_DRAIN;
                end else begin
                    n_i = r_i + NODE_W'(1);
                end
            end
            B_DRAIN: begin
                n_state = B_DEC;
            end
            B_DEC: begin
                if (!r_b2v) begin
                    o_root.en   = 1'b1;
                    o_root.addr = r_row;
                    o_root.data = r_n - NODE_W'(1);
                    n_state     = B_IDLE;
                end else begin
                    we           = 1'b1;
                    o_child.en   = 1'b1;
                    o_child.addr = {r_row, nsub[BYTE_W-1:0]};
                    o_child.data = {r_b2, r_b1};
                    n_state      = B_MARK2;
                end
            end
            B_MARK2: begin
                we = 1'b1;
                if (!r_new) begin
                    waddr   = r_b2;
                    wdata   = {1'b1, r_w2};
                    n_new   = 1'b1;
                end else begin
                    // the joined node enters live, weight wraps at 16 bits
                    waddr = r_n;
                    wdata = {1'b0, r_w1 + r_w2};
                    if (r_n == NODE_W'(2 * SYMBOLS - 1)) begin
                        o_root.en   = 1'b1;
                        o_root.addr = r_row;
                        o_root.data = r_n;
                        n_state     = B_IDLE;
                    end else begin
                        n_n     = r_n + NODE_W'(1);
                        n_state = B_START;
                    end
                end
            end
            default: n_state = B_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= B_IDLE;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
        end
        r_row  <= n_row;
        r_n    <= n_n;
        r_i    <= n_i;
        r_pidx <= n_pidx;
        r_b1   <= n_b1;
        r_b2   <= n_b2;
        r_w1   <= n_w1;
        r_w2   <= n_w2;
        r_b1v  <= n_b1v;
        r_b2v  <= n_b2v;
        r_new  <= n_new;
    end

    assign o_busy = (r_state != B_IDLE);

endmodule
